// File: rtl/awt_pkg.sv
// ----------------------------------------------------------------------------
// awt_pkg
// Shared types, constants and byte classification for the word tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package awt_pkg;

    localparam int MAX_LINE  = 262144;
    localparam int POS_W     = $clog2(MAX_LINE);
    localparam int START_W   = 18;
    localparam int LEN_W     = 6;
    localparam int RUN_W     = 7;
    localparam int TAIL_W    = 7;
    localparam int RUN_CAP   = 64;
    localparam int TAIL_CAP  = 127;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEN_W-1:0] MIN_LEN_RST = 6'd2;
    localparam logic [LEN_W-1:0] MAX_LEN_RST = 6'd32;

    // result queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LEN = 2'd0,
        CFG_MAX_LEN = 2'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CLS_OTHER  = 2'd0,
        CLS_LETTER = 2'd1,
        CLS_DIGIT  = 2'd2,
        CLS_UNDER  = 2'd3
    } t_cls;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_line;
    } t_in_item;

    typedef struct packed {
        logic [START_W-1:0] word_start;
        logic [LEN_W-1:0]   word_length;
        logic               last_of_run;
    } t_out_item;

    // up to two results per byte; v1 only with v0
    typedef struct packed {
        logic      v0;
        t_out_item d0;
        logic      v1;
        t_out_item d1;
    } t_res_pair;

    function automatic t_cls byte_class(input logic [7:0] c);
        if ((c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z)) begin
            return CLS_LETTER;
        end else if (c >= CH_0 && c <= CH_9) begin
            return CLS_DIGIT;
        end else if (c == CH_UNDER) begin
            return CLS_UNDER;
        end
        return CLS_OTHER;
    endfunction

    function automatic logic punct_fits(input t_cls prev, input logic [7:0] c);
        if (prev == CLS_LETTER) begin
            return (c == CH_COLON) || (c == CH_DOT) || (c == CH_APOS);
        end else if (prev == CLS_DIGIT) begin
            return (c == CH_COMMA) || (c == CH_DOT) || (c == CH_APOS) || (c == CH_SEMI);
        end
        return 1'b0;
    endfunction

    // trimmed length: trailing underscores dropped, but at least two kept
    function automatic logic [RUN_W-1:0] word_len(input logic [RUN_W-1:0] run,
                                                  input logic [TAIL_W-1:0] tail);
        if (tail != '0 && run < RUN_W'(2)) begin
            return RUN_W'(2);
        end
        return run;
    endfunction

    function automatic logic [START_W-1:0] to_start(input logic [POS_W-1:0] pos);
        logic [POS_W+START_W-1:0] ext;
        ext = {{START_W{1'b0}}, pos};
        return ext[START_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/awt_core.sv
// ----------------------------------------------------------------------------
// awt_core
// Per-byte word scanner: line state registers and the word close logic.
// ----------------------------------------------------------------------------
`default_nettype none

module awt_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire awt_pkg::t_in_item             i_item,
    input  wire logic [awt_pkg::LEN_W-1:0]     i_min_len,
    input  wire logic [awt_pkg::LEN_W-1:0]     i_max_len,
    output awt_pkg::t_res_pair                 o_res
);

    logic [awt_pkg::POS_W-1:0]  r_pos,   n_pos;
    logic                       r_word,  n_word;
    logic [awt_pkg::POS_W-1:0]  r_begin, n_begin;
    logic [awt_pkg::RUN_W-1:0]  r_run,   n_run;
    logic [awt_pkg::TAIL_W-1:0] r_tail,  n_tail;
    logic                       r_held,  n_held;
    awt_pkg::t_cls              r_prior, n_prior;

    awt_pkg::t_cls              cls;
    logic                       eol;
    logic                       consumed;
    logic                       close_a;
    logic                       close_e;
    logic [awt_pkg::RUN_W:0]    run_plus2;
    logic [awt_pkg::RUN_W:0]    run_plus_tail;
    logic [awt_pkg::TAIL_W:0]   tail_plus1;
    logic [awt_pkg::RUN_W-1:0]  len_a;
    logic [awt_pkg::RUN_W-1:0]  len_e;
    logic                       ok_a;
    logic                       ok_e;
    awt_pkg::t_out_item         item_a;
    awt_pkg::t_out_item         item_e;

    assign cls = awt_pkg::byte_class(i_item.char_byte);
    assign eol = i_item.end_of_line;

    assign run_plus2     = {1'b0, r_run} + (awt_pkg::RUN_W + 1)'(2);
    assign run_plus_tail = {1'b0, r_run} + {1'b0, r_tail} + (awt_pkg::RUN_W + 1)'(1);
    assign tail_plus1    = {1'b0, r_tail} + (awt_pkg::TAIL_W + 1)'(1);

    always_comb begin
        n_pos    = r_pos;
        n_word   = r_word;
        n_begin  = r_begin;
        n_run    = r_run;
        n_tail   = r_tail;
        n_held   = r_held;
        n_prior  = r_prior;
        consumed = 1'b0;
        close_a  = 1'b0;

        // held punctuation is decided by this byte
        if (r_word && r_held) begin
            n_held = 1'b0;
            if ((cls == awt_pkg::CLS_LETTER || cls == awt_pkg::CLS_DIGIT) &&
                cls == r_prior) begin
                n_run    = (run_plus2 > (awt_pkg::RUN_W + 1)'(awt_pkg::RUN_CAP)) ?
                           (awt_pkg::RUN_W)'(awt_pkg::RUN_CAP) :
                           run_plus2[awt_pkg::RUN_W-1:0];
                consumed = 1'b1;
            end else begin
                close_a = 1'b1;
                n_word  = 1'b0;
            end
        end

        if (!consumed) begin
            if (n_word) begin
                if (cls == awt_pkg::CLS_LETTER || cls == awt_pkg::CLS_DIGIT) begin
                    n_run   = (run_plus_tail > (awt_pkg::RUN_W + 1)'(awt_pkg::RUN_CAP)) ?
                              (awt_pkg::RUN_W)'(awt_pkg::RUN_CAP) :
                              run_plus_tail[awt_pkg::RUN_W-1:0];
                    n_tail  = '0;
                    n_prior = cls;
                end else if (cls == awt_pkg::CLS_UNDER) begin
                    n_tail  = (tail_plus1 > (awt_pkg::TAIL_W + 1)'(awt_pkg::TAIL_CAP)) ?
                              (awt_pkg::TAIL_W)'(awt_pkg::TAIL_CAP) :
                              tail_plus1[awt_pkg::TAIL_W-1:0];
                    n_prior = awt_pkg::CLS_UNDER;
                end else if (!eol && awt_pkg::punct_fits(r_prior, i_item.char_byte)) begin
                    n_held = 1'b1;
                end else begin
                    close_a = 1'b1;
                    n_word  = 1'b0;
                end
            end else if (cls == awt_pkg::CLS_LETTER || cls == awt_pkg::CLS_DIGIT) begin
                n_word  = 1'b1;
                n_begin = r_pos;
                n_run   = (awt_pkg::RUN_W)'(1);
                n_tail  = '0;
                n_prior = cls;
            end
        end

        // second close only at end of line, on the word still open
        close_e = eol && n_word;
        len_e   = awt_pkg::word_len(n_run, n_tail);

        if (eol) begin
            n_word  = 1'b0;
            n_held  = 1'b0;
            n_run   = '0;
            n_tail  = '0;
            n_prior = awt_pkg::CLS_OTHER;
            n_pos   = '0;
        end else if (r_pos == (awt_pkg::POS_W)'(awt_pkg::MAX_LINE - 1)) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + (awt_pkg::POS_W)'(1);
        end
    end

    assign len_a = awt_pkg::word_len(r_run, r_tail);

    assign ok_a = close_a &&
                  (len_a >= (awt_pkg::RUN_W)'(i_min_len)) &&
                  (len_a <= (awt_pkg::RUN_W)'(i_max_len));
    assign ok_e = close_e &&
                  (len_e >= (awt_pkg::RUN_W)'(i_min_len)) &&
                  (len_e <= (awt_pkg::RUN_W)'(i_max_len));

    always_comb begin
        item_a.word_start  = awt_pkg::to_start(r_begin);
        item_a.word_length = len_a[awt_pkg::LEN_W-1:0];
        item_a.last_of_run = !ok_e;
        item_e.word_start  = awt_pkg::to_start(n_begin);
        item_e.word_length = len_e[awt_pkg::LEN_W-1:0];
        item_e.last_of_run = 1'b1;

        o_res.v0 = i_fire && (ok_a || ok_e);
        o_res.d0 = ok_a ? item_a : item_e;
        o_res.v1 = i_fire && ok_a && ok_e;
        o_res.d1 = item_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_word  <= 1'b0;
            r_begin <= '0;
            r_run   <= '0;
            r_tail  <= '0;
            r_held  <= 1'b0;
            r_prior <= awt_pkg::CLS_OTHER;
        end else if (i_fire) begin
            r_pos   <= n_pos;
            r_word  <= n_word;
            r_begin <= n_begin;
            r_run   <= n_run;
            r_tail  <= n_tail;
            r_held  <= n_held;
            r_prior <= n_prior;
        end
    end

    // a held byte only exists inside a word that ended in a letter or digit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> (r_word && r_tail == '0 &&
                    (r_prior == awt_pkg::CLS_LETTER || r_prior == awt_pkg::CLS_DIGIT)))
        else $error("awt_core: held punctuation outside a word");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.v1 |-> (o_res.v0 && !o_res.d0.last_of_run && o_res.d1.last_of_run))
        else $error("awt_core: bad last_of_run marking on a result pair");

endmodule

`default_nettype wire

// File: rtl/awt_out_fifo.sv
// ----------------------------------------------------------------------------
// awt_out_fifo
// Small result queue: takes up to two results a cycle while it has room, hands out one while the reader is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module awt_out_fifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire awt_pkg::t_res_pair   i_push,
    output logic                      o_room,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output awt_pkg::t_out_item        o_data
);

    awt_pkg::t_out_item              r_mem [awt_pkg::OUT_DEPTH];
    logic [awt_pkg::OUT_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [awt_pkg::OUT_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [awt_pkg::OUT_CNT_W-1:0]   r_count,  n_count;
    logic [1:0]                      push_n;
    logic                            pop;

    assign push_n  = {1'b0, i_push.v0} + {1'b0, i_push.v1};
    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    // room for a full pair, not counting a pop in the same cycle
    assign o_room  = (r_count <= (awt_pkg::OUT_CNT_W)'(awt_pkg::OUT_DEPTH - 2));

    assign n_wr_ptr = r_wr_ptr + (awt_pkg::OUT_PTR_W)'(push_n);
    assign n_rd_ptr = r_rd_ptr + (awt_pkg::OUT_PTR_W)'(pop);
    assign n_count  = r_count + (awt_pkg::OUT_CNT_W)'(push_n) - (awt_pkg::OUT_CNT_W)'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr_ptr] <= i_push.d0;
        end
        if (i_push.v1) begin
            r_mem[r_wr_ptr + (awt_pkg::OUT_PTR_W)'(1)] <= i_push.d1;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (awt_pkg::OUT_CNT_W)'(awt_pkg::OUT_DEPTH))
        else $error("awt_out_fifo: overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.v0 || i_push.v1) |-> o_room)
        else $error("awt_out_fifo: push without room");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_push.v0 && !pop) |=> $stable(r_count))
        else $error("awt_out_fifo: count moved without a transfer");

endmodule

`default_nettype wire

// File: rtl/ascii_word_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// ascii_word_tokenizer_unit
// Splits ASCII text lines into words and reports start offset and length.
// ----------------------------------------------------------------------------
// Takes one byte per cycle on the input channel, with end_of_line on the
// last byte of each line, and emits one result per reported word. A byte
// goes through an input register, the scanner updates line state, and its
// results land in a 4-entry queue that drives the output. Sustained rate is
// one byte per cycle while the queue has room; the output port moves one
// result per cycle while the reader is ready, so a byte that closes two
// words (a rejected punctuation byte followed by a final one-character word
// at end of line) leaves the extra result in the queue. Input is held off
// only while the queue lacks room for two results. Configuration writes are
// always ready and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_word_tokenizer_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire awt_pkg::t_in_item               i_in_data,

    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output awt_pkg::t_out_item                   o_out_data,

    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [awt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [awt_pkg::LEN_W-1:0]       i_cfg_data
);

    logic                         r_in_valid;
    awt_pkg::t_in_item            r_in_item;
    logic [awt_pkg::LEN_W-1:0]    r_min_len;
    logic [awt_pkg::LEN_W-1:0]    r_max_len;
    logic                         fifo_room;
    logic                         fire;
    logic                         cfg_xfer;
    awt_pkg::t_res_pair           res;

    assign fire        = r_in_valid && fifo_room;
    assign o_in_ready  = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
    end

    // unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= awt_pkg::MIN_LEN_RST;
            r_max_len <= awt_pkg::MAX_LEN_RST;
        end else if (cfg_xfer) begin
            if (i_cfg_index == awt_pkg::CFG_MIN_LEN) begin
                r_min_len <= i_cfg_data;
            end
            if (i_cfg_index == awt_pkg::CFG_MAX_LEN) begin
                r_max_len <= i_cfg_data;
            end
        end
    end

    awt_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_item    (r_in_item),
        .i_min_len (r_min_len),
        .i_max_len (r_max_len),
        .o_res     (res)
    );

    awt_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res),
        .o_room  (fifo_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> (r_in_valid && $stable(r_in_item)))
        else $error("ascii_word_tokenizer_unit: stalled input register changed");

endmodule

`default_nettype wire

// File: sim/ascii_word_tokenizer_unit_tb.sv
// ----------------------------------------------------------------------------
// ascii_word_tokenizer_unit_tb
// Self-checking bench for the word tokenizer.
// A short scripted set of lines covers the corner cases: high bytes and NUL,
// punctuation joins and rejects, trimmed underscores, and a byte that closes
// two words. Random text lines follow under several length bounds and
// handshake pressure. Every word on the output is checked against the words
// due, taken from an in-bench tokenizer or written out in the script.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_word_tokenizer_unit_tb;

    localparam int DRAIN_CYCLES   = 6;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int BLOCK_BYTES    = 75;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    awt_pkg::t_in_item             i_in_data;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    awt_pkg::t_out_item            o_out_data;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [awt_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [awt_pkg::LEN_W-1:0]     i_cfg_data;

    ascii_word_tokenizer_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // tokenizer state, mirrors the block
    logic [awt_pkg::LEN_W-1:0]   bound_lo = awt_pkg::MIN_LEN_RST;
    logic [awt_pkg::LEN_W-1:0]   bound_hi = awt_pkg::MAX_LEN_RST;
    logic [awt_pkg::POS_W-1:0]   line_pos = '0;
    logic                        open_word = 1'b0;
    logic [awt_pkg::START_W-1:0] word_origin = '0;
    logic [awt_pkg::RUN_W-1:0]   body_len = '0;
    logic [awt_pkg::TAIL_W-1:0]  under_run = '0;
    logic                        pend_punct = 1'b0;
    awt_pkg::t_cls               last_cls = awt_pkg::CLS_OTHER;

    awt_pkg::t_out_item closed_words[$];
    awt_pkg::t_out_item words_due[$];
    bit                 mismatch_seen = 1'b0;
    int                 send_gap_pct = 0;
    int                 out_stall_pct = 0;

    typedef struct {
        int ch;
        int eol;
        int cnt;   // -1: take the words from the tokenizer model
        int s0;
        int l0;
        int s1;
        int l1;
    } t_script_row;

    t_script_row script[24];

    function automatic int clip(input int v, input int lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic awt_pkg::t_cls classify_byte(input logic [7:0] c);
        if (c inside {[awt_pkg::CH_UP_A:awt_pkg::CH_UP_Z],
                      [awt_pkg::CH_LO_A:awt_pkg::CH_LO_Z]}) begin
            return awt_pkg::CLS_LETTER;
        end
        if (c inside {[awt_pkg::CH_0:awt_pkg::CH_9]}) begin
            return awt_pkg::CLS_DIGIT;
        end
        return (c == awt_pkg::CH_UNDER) ? awt_pkg::CLS_UNDER : awt_pkg::CLS_OTHER;
    endfunction

    function automatic bit punct_joins(input awt_pkg::t_cls prev, input logic [7:0] c);
        case (prev)
            awt_pkg::CLS_LETTER: return c inside {awt_pkg::CH_COLON, awt_pkg::CH_DOT,
                                                  awt_pkg::CH_APOS};
            awt_pkg::CLS_DIGIT:  return c inside {awt_pkg::CH_COMMA, awt_pkg::CH_DOT,
                                                  awt_pkg::CH_APOS, awt_pkg::CH_SEMI};
            default:             return 1'b0;
        endcase
    endfunction

    function automatic void close_open_word();
        int len;
        len = body_len;
        if (under_run != 0 && len < 2) len = 2;
        open_word  = 1'b0;
        pend_punct = 1'b0;
        if (len >= int'(bound_lo) && len <= int'(bound_hi) && closed_words.size() < 2) begin
            closed_words.push_back('{word_start: word_origin,
                                     word_length: awt_pkg::LEN_W'(len),
                                     last_of_run: 1'b0});
        end
    endfunction

    // one byte through the tokenizer; words it closes end up in closed_words
    function automatic void tokenize_byte(input awt_pkg::t_in_item it);
        awt_pkg::t_cls      cls;
        bit                 joined;
        awt_pkg::t_out_item tail_word;
        cls    = classify_byte(it.char_byte);
        joined = 1'b0;
        closed_words.delete();

        // a held punctuation byte is decided by its right neighbor
        if (open_word && pend_punct) begin
            pend_punct = 1'b0;
            if ((cls == awt_pkg::CLS_LETTER || cls == awt_pkg::CLS_DIGIT) &&
                cls == last_cls) begin
                body_len = awt_pkg::RUN_W'(clip(int'(body_len) + 2, awt_pkg::RUN_CAP));
                joined   = 1'b1;
            end else begin
                close_open_word();
            end
        end

        if (!joined) begin
            if (open_word) begin
                if (cls == awt_pkg::CLS_LETTER || cls == awt_pkg::CLS_DIGIT) begin
                    body_len  = awt_pkg::RUN_W'(clip(int'(body_len) + int'(under_run) + 1,
                                                     awt_pkg::RUN_CAP));
                    under_run = '0;
                    last_cls  = cls;
                end else if (cls == awt_pkg::CLS_UNDER) begin
                    under_run = awt_pkg::TAIL_W'(clip(int'(under_run) + 1, awt_pkg::TAIL_CAP));
                    last_cls  = awt_pkg::CLS_UNDER;
                end else if (!it.end_of_line && punct_joins(last_cls, it.char_byte)) begin
                    pend_punct = 1'b1;
                end else begin
                    close_open_word();
                end
            end else if (cls == awt_pkg::CLS_LETTER || cls == awt_pkg::CLS_DIGIT) begin
                open_word   = 1'b1;
                word_origin = awt_pkg::START_W'(line_pos);
                body_len    = awt_pkg::RUN_W'(1);
                under_run   = '0;
                last_cls    = cls;
            end
        end

        if (it.end_of_line) begin
            if (open_word) close_open_word();
            open_word  = 1'b0;
            pend_punct = 1'b0;
            body_len   = '0;
            under_run  = '0;
            last_cls   = awt_pkg::CLS_OTHER;
            line_pos   = '0;
        end else begin
            line_pos = (int'(line_pos) + 1 >= awt_pkg::MAX_LINE) ? '0 : line_pos + 1'b1;
        end

        if (closed_words.size() > 0) begin
            tail_word = closed_words.pop_back();
            tail_word.last_of_run = 1'b1;
            closed_words.push_back(tail_word);
        end
    endfunction

    function automatic logic [7:0] rand_text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 35) return awt_pkg::CH_LO_A + 8'($urandom_range(25));
        if (r < 45) return awt_pkg::CH_UP_A + 8'($urandom_range(25));
        if (r < 60) return awt_pkg::CH_0 + 8'($urandom_range(9));
        if (r < 68) return awt_pkg::CH_UNDER;
        if (r < 84) begin
            case ($urandom_range(4))
                0:       return awt_pkg::CH_COLON;
                1:       return awt_pkg::CH_DOT;
                2:       return awt_pkg::CH_APOS;
                3:       return awt_pkg::CH_COMMA;
                default: return awt_pkg::CH_SEMI;
            endcase
        end
        if (r < 94) return 8'h20;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_byte(input logic [7:0] ch, input logic eol, input bit from_model);
        awt_pkg::t_in_item it;
        it = '{char_byte: ch, end_of_line: eol};
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tokenize_byte(it);
        if (from_model) begin
            foreach (closed_words[k]) words_due.push_back(closed_words[k]);
        end
    endtask

    // returns the number of bytes sent
    task automatic send_random_line(output int nbytes);
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 5) begin
            // word longer than any bound, run length saturates
            n = $urandom_range(64, 80);
            for (int i = 0; i < n; i++) begin
                send_byte(awt_pkg::CH_LO_A + 8'($urandom_range(25)), 1'b0, 1'b1);
            end
            send_byte(8'h20, 1'b1, 1'b1);
            nbytes = n + 1;
        end else if (r < 10) begin
            // underscore tail up to and past its saturation point
            n = $urandom_range(120, 135);
            send_byte(awt_pkg::CH_LO_A + 8'($urandom_range(25)), 1'b0, 1'b1);
            for (int i = 0; i < n; i++) send_byte(awt_pkg::CH_UNDER, 1'b0, 1'b1);
            send_byte(rand_text_byte(), 1'b1, 1'b1);
            nbytes = n + 2;
        end else if (r < 20) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                send_byte(8'($urandom_range(255)), i == n - 1, 1'b1);
            end
            nbytes = n;
        end else begin
            n = $urandom_range(1, 30);
            for (int i = 0; i < n; i++) send_byte(rand_text_byte(), i == n - 1, 1'b1);
            nbytes = n;
        end
    endtask

    // bounds change only with the block drained
    task automatic set_length_bounds(input int lo, input int hi);
        i_in_valid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= awt_pkg::CFG_MIN_LEN;
        i_cfg_data  <= awt_pkg::LEN_W'(lo);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        bound_lo = awt_pkg::LEN_W'(lo);
        i_cfg_index <= awt_pkg::CFG_MAX_LEN;
        i_cfg_data  <= awt_pkg::LEN_W'(hi);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        bound_hi = awt_pkg::LEN_W'(hi);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin : out_side
        awt_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (words_due.size() == 0) begin
                $display("%0t: unexpected word, expected none, got start=%0d len=%0d last=%0b",
                         $time, o_out_data.word_start, o_out_data.word_length,
                         o_out_data.last_of_run);
                mismatch_seen = 1'b1;
            end else begin
                want = words_due.pop_front();
                if (o_out_data.word_start !== want.word_start ||
                    o_out_data.word_length !== want.word_length ||
                    o_out_data.last_of_run !== want.last_of_run) begin
                    $display({"%0t: word mismatch, expected start=%0d len=%0d last=%0b,",
                              " got start=%0d len=%0d last=%0b"},
                             $time, want.word_start, want.word_length, want.last_of_run,
                             o_out_data.word_start, o_out_data.word_length,
                             o_out_data.last_of_run);
                    mismatch_seen = 1'b1;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int gap_sel[3];
        int stall_sel[3];
        int lo_sel[9];
        int hi_sel[9];
        int sent;
        int nb;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = awt_pkg::CFG_MIN_LEN;
        i_cfg_data  = '0;

        gap_sel   = '{7, 60, 0};
        stall_sel = '{60, 7, 0};
        lo_sel    = '{2, 0, 5, 63, 40, 3, 1, 0, 6};
        hi_sel    = '{32, 10, 5, 63, 1, 63, 1, 63, 20};

        // lines: "a" | "ab" | NUL "Z_" 0xFF | "9,5." | "don'7:q; " | "ab:1"
        script = '{
            '{8'h61, 1,  1, 0, 1, 0, 0},
            '{8'h61, 0, -1, 0, 0, 0, 0},
            '{8'h62, 1,  1, 0, 2, 0, 0},
            '{8'h00, 0, -1, 0, 0, 0, 0},
            '{8'h5A, 0, -1, 0, 0, 0, 0},
            '{8'h5F, 0, -1, 0, 0, 0, 0},
            '{8'hFF, 1,  1, 1, 2, 0, 0},   // one letter plus underscore keeps two
            '{8'h39, 0, -1, 0, 0, 0, 0},
            '{8'h2C, 0, -1, 0, 0, 0, 0},
            '{8'h35, 0, -1, 0, 0, 0, 0},
            '{8'h2E, 1,  1, 0, 3, 0, 0},   // dot on the last byte stays out
            '{8'h64, 0, -1, 0, 0, 0, 0},
            '{8'h6F, 0, -1, 0, 0, 0, 0},
            '{8'h6E, 0, -1, 0, 0, 0, 0},
            '{8'h27, 0, -1, 0, 0, 0, 0},
            '{8'h37, 0,  1, 0, 3, 0, 0},   // digit after letter rejects the apostrophe
            '{8'h3A, 0,  1, 4, 1, 0, 0},
            '{8'h71, 0, -1, 0, 0, 0, 0},
            '{8'h3B, 0,  1, 6, 1, 0, 0},
            '{8'h20, 1,  0, 0, 0, 0, 0},
            '{8'h61, 0, -1, 0, 0, 0, 0},
            '{8'h62, 0, -1, 0, 0, 0, 0},
            '{8'h3A, 0, -1, 0, 0, 0, 0},
            '{8'h31, 1,  2, 0, 2, 3, 1}    // closes two words in one byte
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_gap_pct  = gap_sel[0];
        out_stall_pct = stall_sel[0];
        set_length_bounds(1, 63);
        foreach (script[k]) begin
            send_byte(script[k].ch[7:0], script[k].eol[0], script[k].cnt < 0);
            if (script[k].cnt > 0) begin
                words_due.push_back('{word_start: awt_pkg::START_W'(script[k].s0),
                                      word_length: awt_pkg::LEN_W'(script[k].l0),
                                      last_of_run: script[k].cnt == 1});
            end
            if (script[k].cnt > 1) begin
                words_due.push_back('{word_start: awt_pkg::START_W'(script[k].s1),
                                      word_length: awt_pkg::LEN_W'(script[k].l1),
                                      last_of_run: 1'b1});
            end
        end

        for (int p = 0; p < 3; p++) begin
            send_gap_pct  = gap_sel[p];
            out_stall_pct = stall_sel[p];
            for (int b = 0; b < 3; b++) begin
                set_length_bounds(lo_sel[p * 3 + b], hi_sel[p * 3 + b]);
                sent = 0;
                while (sent < BLOCK_BYTES) begin
                    send_random_line(nb);
                    sent += nb;
                end
            end
        end
        i_in_valid <= 1'b0;

        while (words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!mismatch_seen && words_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
